[hw/rtl/slfr_pkg.sv]
package slfr_pkg;

  // frame format
  localparam int MAX_FRAME   = 64;
  localparam int LEN_CAP     = 64;
  localparam int LEN_LIMIT   = (MAX_FRAME < LEN_CAP) ? MAX_FRAME : LEN_CAP;
  localparam int MIN_LEN     = 5;
  localparam int HDR_BYTES   = 4;
  localparam int STORE_DEPTH = 60;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0] LEN_MIN_B = 8'(MIN_LEN);
  localparam logic [7:0] LEN_MAX_B = 8'(LEN_LIMIT);
  localparam logic [7:0] HDR_B     = 8'(HDR_BYTES);

  // field widths
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(1);
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // receiver states
  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_LEN,
    ST_BODY,
    ST_DRAIN
  } state_t;

  // payload store access request
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [BYTE_W-1:0]   wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } ram_req_t;

endpackage

[hw/rtl/slfr_if.sv]
// received byte channel
interface slfr_rx_if import slfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// payload result channel
interface slfr_out_if import slfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              last_of_frame;

  modport source (output valid, output payload_byte, output byte_index,
                  output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input last_of_frame, output ready);
endinterface

// configuration write channel
interface slfr_cfg_if import slfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/slfr_ram.sv]
module slfr_ram import slfr_pkg::*; (
  input  logic              clk,
  input  ram_req_t          req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

[hw/rtl/slfr_ctrl.sv]
module slfr_ctrl import slfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  slfr_rx_if.sink           rx,
  slfr_out_if.source        frame,
  slfr_cfg_if.sink          cfg,
  input  logic [BYTE_W-1:0] rd_data,
  output ram_req_t          ram_req
);

  state_t            state, state_next;
  logic [BYTE_W-1:0] sync_first, sync_second;
  logic [IDX_W-1:0]  pay_count, pay_count_next;
  logic [IDX_W-1:0]  slot, slot_next;
  logic [BYTE_W-1:0] run_sum, run_sum_next;
  logic              out_valid, out_valid_next;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;
  logic              rx_ok;
  logic              take;
  logic              rd_last;
  logic [BYTE_W-1:0] b;

  assign b        = rx.rx_byte;
  assign rx.ready = (state != ST_DRAIN);
  assign rx_ok    = rx.valid && rx.ready;
  assign take     = !out_valid || frame.ready;
  assign rd_last  = (slot == pay_count - IDX_W'(1));

  assign cfg.ready = 1'b1;

  assign frame.valid         = out_valid;
  assign frame.payload_byte  = rd_data;
  assign frame.byte_index    = out_index;
  assign frame.last_of_frame = out_last;

  // sync byte registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SYNC_FIRST:  sync_first  <= cfg.data;
        REG_SYNC_SECOND: sync_second <= cfg.data;
        default: ;
      endcase
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SYNC1;
      out_valid <= 1'b0;
      slot      <= '0;
      pay_count <= '0;
      run_sum   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      slot      <= slot_next;
      pay_count <= pay_count_next;
      run_sum   <= run_sum_next;
    end
  end

  // result tag, loaded with each store read
  always_ff @(posedge clk) begin
    if (ram_req.re) begin
      out_index <= slot;
      out_last  <= rd_last;
    end
  end

  // next state, store access and checksum
  always_comb begin
    state_next     = state;
    slot_next      = slot;
    pay_count_next = pay_count;
    run_sum_next   = run_sum;
    out_valid_next = take ? 1'b0 : out_valid;
    ram_req        = '0;
    ram_req.waddr  = slot[STORE_AW-1:0];
    ram_req.wdata  = b;
    ram_req.raddr  = slot[STORE_AW-1:0];
    unique case (state)
      ST_SYNC1: begin
        if (rx_ok && b == sync_first) state_next = ST_SYNC2;
      end
      ST_SYNC2: begin
        if (rx_ok) state_next = (b == sync_second) ? ST_LEN : ST_SYNC1;
      end
      ST_LEN: begin
        if (rx_ok) begin
          if (b < LEN_MIN_B || b > LEN_MAX_B) begin
            state_next = ST_SYNC1;
          end else begin
            pay_count_next = IDX_W'(b - HDR_B);
            run_sum_next   = sync_first + sync_second + b;
            slot_next      = '0;
            state_next     = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (rx_ok) begin
          if (slot != pay_count) begin
            ram_req.we   = 1'b1;
            run_sum_next = run_sum + b;
            slot_next    = slot + IDX_W'(1);
          end else if (b == run_sum) begin
            slot_next  = '0;
            state_next = ST_DRAIN;
          end else begin
            state_next = ST_SYNC1;
          end
        end
      end
      ST_DRAIN: begin
        if (take) begin
          ram_req.re     = 1'b1;
          out_valid_next = 1'b1;
          slot_next      = slot + IDX_W'(1);
          if (rd_last) state_next = ST_SYNC1;
        end
      end
      default: state_next = ST_SYNC1;
    endcase
  end

endmodule

[hw/rtl/sync_length_sum_frame_receiver.sv]
// Frame receiver: takes one received byte per cycle, hunts for the two sync
// bytes, reads the length byte L (5 to 64), stores the L-4 payload bytes in
// an on-chip memory while summing the frame mod 256, and checks the final
// byte against that sum. A good frame is then read back from the memory one
// byte per cycle while the output is not stalled, as L-4 results tagged with
// their index and a last flag. Byte input is held off while a frame drains.
// Bad lengths, a wrong second sync byte or a checksum mismatch drop back to
// hunting with no result. Sync bytes are writable at index 0 and 1 (reset
// 0xAA and 0x55); other indexes are ignored.
module sync_length_sum_frame_receiver import slfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  slfr_rx_if.sink    rx,
  slfr_out_if.source frame,
  slfr_cfg_if.sink   cfg
);

  ram_req_t          ram_req;
  logic [BYTE_W-1:0] rd_data;

  // receive control, checksum and drain sequencing
  slfr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .frame   (frame),
    .cfg     (cfg),
    .rd_data (rd_data),
    .ram_req (ram_req)
  );

  // payload store
  slfr_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // store is never read and written in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(ram_req.we && ram_req.re))
    else $error("payload store read and write overlap");

  // reads only happen while byte input is held off
  assert property (@(posedge clk) disable iff (rst) ram_req.re |-> !rx.ready)
    else $error("payload read while accepting bytes");

  // after a non-final byte is taken the next index follows at once
  assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ready && !frame.last_of_frame |=>
      frame.valid && frame.byte_index == IDX_W'($past(frame.byte_index) + 1))
    else $error("payload drain skipped or stalled an index");
`endif

endmodule
